// ===== rtl/core/ptik_pkg.sv =====
// ----------------------------------------------------------------------------
// ptik_pkg
// Shared types, fixed-point constants and helpers for the platform tilt
// inverse kinematics pipeline (Q.30 intermediate format).
// ----------------------------------------------------------------------------
package ptik_pkg;

   localparam int QF            = 30;   // fraction bits of intermediates
   localparam int MUL_W         = 36;   // width of Q.30 operands
   localparam int WIDE_W        = 64;   // width of squares and root argument
   localparam int ROOT_W        = 32;   // root bits, one per root stage
   localparam int ATAN_IN_W     = 40;   // width of atan numerator and denominator
   localparam int ATAN_W        = 54;   // width of the vectoring datapath
   localparam int SHIFT_W       = 6;    // width of the normalize shift count
   localparam int NORM_MSB      = 50;   // normalize until a value reaches 2^50
   localparam int ANG_W         = 15;   // result angle width
   localparam int TILT_W        = 16;   // input angle width
   localparam int ARC_N         = 32;   // entries of the arctangent table
   localparam int AFB_DEFAULT   = 13;
   localparam int STEPS_DEFAULT = 16;

   typedef logic signed [MUL_W-1:0]     mval_type;
   typedef logic signed [WIDE_W-1:0]    wide_type;
   typedef logic signed [ATAN_IN_W-1:0] ain_type;
   typedef logic signed [ATAN_W-1:0]    atw_type;

   localparam mval_type Q_PI      = 36'sd3373259426;
   localparam mval_type Q_TWO_PI  = 36'sd6746518852;
   localparam mval_type Q_HALF_PI = 36'sd1686629713;
   localparam mval_type Q_GAIN    = 36'sd652032874;
   localparam mval_type Q_SQRT3   = 36'sd1859775393;
   localparam mval_type K_00125   = 36'sd1342177;
   localparam mval_type K_00325   = 36'sd3489661;
   localparam mval_type K_0025    = 36'sd2684355;
   localparam mval_type K_002975  = 36'sd3194382;
   localparam mval_type K_004225  = 36'sd4536559;
   localparam mval_type K_005     = 36'sd53687091;
   localparam mval_type K_013     = 36'sd139586437;
   localparam mval_type K_001     = 36'sd10737418;
   localparam mval_type K_0013    = 36'sd13958644;
   localparam mval_type K_0119    = 36'sd12777528;
   localparam mval_type K_0169    = 36'sd18146237;
   localparam mval_type K_01      = 36'sd107374182;

   // atan(2^-i) in Q.30
   localparam mval_type ARC_TAB [ARC_N] = '{
      36'sh03243F6A8, 36'sh01DAC6705, 36'sh00FADBAFC, 36'sh007F56EA6,
      36'sh003FEAB76, 36'sh001FFD55B, 36'sh000FFFAAA, 36'sh0007FFF55,
      36'sh0003FFFEA, 36'sh0001FFFFD, 36'sh0000FFFFF, 36'sh00007FFFF,
      36'sh00003FFFF, 36'sh00001FFFF, 36'sh00000FFFF, 36'sh000007FFF,
      36'sh000003FFF, 36'sh000001FFF, 36'sh000000FFF, 36'sh0000007FF,
      36'sh0000003FF, 36'sh0000001FF, 36'sh0000000FF, 36'sh00000007F,
      36'sh00000003F, 36'sh00000001F, 36'sh00000000F, 36'sh000000008,
      36'sh000000004, 36'sh000000002, 36'sh000000001, 36'sh000000000
   };

   // Q.30 product, rounded to nearest with ties toward +infinity
   function automatic mval_type qmul(input mval_type a, input mval_type b);
      logic signed [2*MUL_W-1:0] p;
      p = a * b;
      p = p + ((2*MUL_W)'(64'sd1 <<< (QF - 1)));
      p = p >>> QF;
      return p[MUL_W-1:0];
   endfunction

   // exact square, 60 fraction bits
   function automatic wide_type sqr(input mval_type a);
      logic signed [2*MUL_W-1:0] p;
      p = a * a;
      return p[WIDE_W-1:0];
   endfunction

   // position of the highest set bit
   function automatic logic [SHIFT_W-1:0] msb_pos(input logic [ATAN_IN_W-1:0] v);
      logic [SHIFT_W-1:0] r;
      r = '0;
      for (int i = 0; i < ATAN_IN_W; i++) begin
         if (v[i]) begin
            r = SHIFT_W'(i);
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/ptik_delay.sv =====
// ----------------------------------------------------------------------------
// ptik_delay
// Enabled shift line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module ptik_delay #(
   parameter int W     = 1,
   parameter int DEPTH = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);

   logic [W-1:0] sr_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         sr_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) begin
            sr_ff[i] <= sr_ff[i-1];
         end
      end
   end

   assign q = sr_ff[DEPTH-1];

endmodule

// ===== rtl/core/ptik_sincos.sv =====
// ----------------------------------------------------------------------------
// ptik_sincos
// Pipelined rotation CORDIC: range reduction, quadrant fold, one stage per
// iteration, sign fix.
// ----------------------------------------------------------------------------
module ptik_sincos #(
   parameter int AFB   = ptik_pkg::AFB_DEFAULT,
   parameter int STEPS = ptik_pkg::STEPS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic signed [ptik_pkg::TILT_W-1:0]   tilt,
   output ptik_pkg::mval_type                   sin_q,
   output ptik_pkg::mval_type                   cos_q
);

   localparam int SH = ptik_pkg::QF - AFB;
   localparam int ZW = (ptik_pkg::TILT_W + 1 + SH > ptik_pkg::MUL_W) ?
                       (ptik_pkg::TILT_W + 1 + SH) : ptik_pkg::MUL_W;
   localparam longint ZMAX = longint'(1) <<< (ptik_pkg::TILT_W - 1 + SH);
   localparam int NRED = int'(ZMAX / longint'(ptik_pkg::Q_TWO_PI)) + 1;

   typedef logic signed [ZW-1:0] zred_type;

   zred_type           z_red;
   ptik_pkg::mval_type z_fold;
   logic               neg_fold;

   ptik_pkg::mval_type zf_ff;
   logic               negf_ff;

   ptik_pkg::mval_type x_ff [STEPS];
   ptik_pkg::mval_type y_ff [STEPS];
   ptik_pkg::mval_type z_ff [STEPS];
   ptik_pkg::mval_type x_in [STEPS];
   ptik_pkg::mval_type y_in [STEPS];
   ptik_pkg::mval_type z_in [STEPS];
   logic [STEPS-1:0]   neg_ff;

   ptik_pkg::mval_type sin_ff;
   ptik_pkg::mval_type cos_ff;

   // modulo 2*pi into [-pi, pi], then fold into [-pi/2, pi/2]
   always_comb begin
      z_red = zred_type'(tilt) <<< SH;
      for (int i = 0; i < NRED; i++) begin
         if (z_red > zred_type'(ptik_pkg::Q_PI)) begin
            z_red = z_red - zred_type'(ptik_pkg::Q_TWO_PI);
         end else if (z_red < -zred_type'(ptik_pkg::Q_PI)) begin
            z_red = z_red + zred_type'(ptik_pkg::Q_TWO_PI);
         end
      end
      z_fold   = ptik_pkg::mval_type'(z_red);
      neg_fold = 1'b0;
      if (z_fold > ptik_pkg::Q_HALF_PI) begin
         z_fold   = z_fold - ptik_pkg::Q_PI;
         neg_fold = 1'b1;
      end else if (z_fold < -ptik_pkg::Q_HALF_PI) begin
         z_fold   = z_fold + ptik_pkg::Q_PI;
         neg_fold = 1'b1;
      end
   end

   always_comb begin
      for (int i = 0; i < STEPS; i++) begin
         ptik_pkg::mval_type xp;
         ptik_pkg::mval_type yp;
         ptik_pkg::mval_type zp;
         xp = (i == 0) ? ptik_pkg::Q_GAIN : x_ff[(i == 0) ? 0 : i-1];
         yp = (i == 0) ? '0 : y_ff[(i == 0) ? 0 : i-1];
         zp = (i == 0) ? zf_ff : z_ff[(i == 0) ? 0 : i-1];
         if (zp >= 0) begin
            x_in[i] = xp - (yp >>> i);
            y_in[i] = yp + (xp >>> i);
            z_in[i] = zp - ptik_pkg::ARC_TAB[i];
         end else begin
            x_in[i] = xp + (yp >>> i);
            y_in[i] = yp - (xp >>> i);
            z_in[i] = zp + ptik_pkg::ARC_TAB[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zf_ff   <= z_fold;
         negf_ff <= neg_fold;
         for (int i = 0; i < STEPS; i++) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
            z_ff[i] <= z_in[i];
         end
         // fold flag travels beside the iteration stages
         neg_ff <= {neg_ff[STEPS-2:0], negf_ff};
         cos_ff <= neg_ff[STEPS-1] ? -x_ff[STEPS-1] : x_ff[STEPS-1];
         sin_ff <= neg_ff[STEPS-1] ? -y_ff[STEPS-1] : y_ff[STEPS-1];
      end
   end

   assign sin_q = sin_ff;
   assign cos_q = cos_ff;

endmodule

// ===== rtl/core/ptik_isqrt.sv =====
// ----------------------------------------------------------------------------
// ptik_isqrt
// Pipelined truncating integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module ptik_isqrt (
   input  logic                               clock,
   input  logic                               en,
   input  logic [ptik_pkg::WIDE_W-1:0]        arg,
   output logic [ptik_pkg::ROOT_W-1:0]        root
);

   localparam int N = ptik_pkg::ROOT_W;
   localparam int W = ptik_pkg::WIDE_W;

   logic [W-1:0] v_ff [N];
   logic [W-1:0] r_ff [N];
   logic [W-1:0] v_in [N];
   logic [W-1:0] r_in [N];

   always_comb begin
      for (int i = 0; i < N; i++) begin
         logic [W-1:0] vp;
         logic [W-1:0] rp;
         logic [W-1:0] bitv;
         vp   = (i == 0) ? arg : v_ff[(i == 0) ? 0 : i-1];
         rp   = (i == 0) ? '0  : r_ff[(i == 0) ? 0 : i-1];
         bitv = W'(1) << (W - 2 - 2*i);
         if (vp >= rp + bitv) begin
            v_in[i] = vp - (rp + bitv);
            r_in[i] = (rp >> 1) + bitv;
         end else begin
            v_in[i] = vp;
            r_in[i] = rp >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < N; i++) begin
            v_ff[i] <= v_in[i];
            r_ff[i] <= r_in[i];
         end
      end
   end

   assign root = r_ff[N-1][N-1:0];

endmodule

// ===== rtl/core/ptik_atan.sv =====
// ----------------------------------------------------------------------------
// ptik_atan
// atan(num/den): sign fix, normalize search, normalize shift, vectoring
// CORDIC stages, clamp and round.
// ----------------------------------------------------------------------------
module ptik_atan #(
   parameter int AFB   = ptik_pkg::AFB_DEFAULT,
   parameter int STEPS = ptik_pkg::STEPS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               en,
   input  ptik_pkg::ain_type                  num,
   input  ptik_pkg::mval_type                 den,
   output logic [ptik_pkg::ANG_W-1:0]         ang
);

   localparam int SH = ptik_pkg::QF - AFB;
   localparam int AW = ptik_pkg::ATAN_IN_W;
   localparam int SW = ptik_pkg::SHIFT_W;

   ptik_pkg::ain_type  x0_ff, y0_ff, x1_ff, y1_ff;
   logic [SW-1:0]      sh_ff;
   ptik_pkg::atw_type  x2_ff, y2_ff;

   ptik_pkg::atw_type  x_ff [STEPS];
   ptik_pkg::atw_type  y_ff [STEPS];
   ptik_pkg::mval_type z_ff [STEPS];
   ptik_pkg::atw_type  x_in [STEPS];
   ptik_pkg::atw_type  y_in [STEPS];
   ptik_pkg::mval_type z_in [STEPS];

   logic [ptik_pkg::ANG_W-1:0] ang_ff;

   ptik_pkg::ain_type  x0_in, y0_in;
   logic [AW-1:0]      ay;
   logic [SW-1:0]      sx, sy, sh_in;
   ptik_pkg::mval_type zc;
   ptik_pkg::mval_type zr;

   // make the denominator positive
   always_comb begin
      if (den < 0) begin
         x0_in = -ptik_pkg::ain_type'(den);
         y0_in = -num;
      end else begin
         x0_in = ptik_pkg::ain_type'(den);
         y0_in = num;
      end
   end

   // doublings until either value reaches 2^50 in magnitude
   always_comb begin
      ay    = (y0_ff < 0) ? AW'(-y0_ff) : AW'(y0_ff);
      sx    = SW'(ptik_pkg::NORM_MSB) - ptik_pkg::msb_pos(AW'(x0_ff));
      sy    = SW'(ptik_pkg::NORM_MSB) - ptik_pkg::msb_pos(ay);
      sh_in = (y0_ff == 0 || sx < sy) ? sx : sy;
   end

   always_comb begin
      for (int i = 0; i < STEPS; i++) begin
         ptik_pkg::atw_type  xp;
         ptik_pkg::atw_type  yp;
         ptik_pkg::mval_type zp;
         xp = (i == 0) ? x2_ff : x_ff[(i == 0) ? 0 : i-1];
         yp = (i == 0) ? y2_ff : y_ff[(i == 0) ? 0 : i-1];
         zp = (i == 0) ? '0    : z_ff[(i == 0) ? 0 : i-1];
         if (yp < 0) begin
            x_in[i] = xp - (yp >>> i);
            y_in[i] = yp + (xp >>> i);
            z_in[i] = zp - ptik_pkg::ARC_TAB[i];
         end else begin
            x_in[i] = xp + (yp >>> i);
            y_in[i] = yp - (xp >>> i);
            z_in[i] = zp + ptik_pkg::ARC_TAB[i];
         end
      end
   end

   // clamp to +-pi/2, round to the output fraction
   always_comb begin
      zc = z_ff[STEPS-1];
      if (zc > ptik_pkg::Q_HALF_PI) begin
         zc = ptik_pkg::Q_HALF_PI;
      end else if (zc < -ptik_pkg::Q_HALF_PI) begin
         zc = -ptik_pkg::Q_HALF_PI;
      end
      zr = (zc + (ptik_pkg::mval_type'(1) <<< (SH - 1))) >>> SH;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff <= x0_in;
         y0_ff <= y0_in;
         x1_ff <= x0_ff;
         y1_ff <= y0_ff;
         sh_ff <= sh_in;
         x2_ff <= ptik_pkg::atw_type'(x1_ff) <<< sh_ff;
         y2_ff <= ptik_pkg::atw_type'(y1_ff) <<< sh_ff;
         for (int i = 0; i < STEPS; i++) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
            z_ff[i] <= z_in[i];
         end
         ang_ff <= zr[ptik_pkg::ANG_W-1:0];
      end
   end

   assign ang = ang_ff;

endmodule

// ===== rtl/core/platform_tilt_inverse_kinematics_top.sv =====
// ----------------------------------------------------------------------------
// platform_tilt_inverse_kinematics_top
// Joint angles of a three-legged tilt platform from two tilt angles.
// ----------------------------------------------------------------------------
// One request carries tilt_x and tilt_y (signed, AFB fraction bits, radians);
// each request gives exactly one response with the three leg joint angles in
// the same format and a pose_invalid flag. A request can enter every clock
// cycle while req_stall is low. The pipeline runs through the sin/cos
// CORDIC, seven stages of multiply and add for the leg terms, the square
// root (one stage per root bit, 32), one stage for the atan numerator, the
// atan CORDIC and the output register. While a response sits in the output
// register with rsp_stall high, the whole pipeline holds and req_stall is
// high. When a leg's root argument is negative or its denominator is zero,
// pose_invalid is set and all three angles read zero.
module platform_tilt_inverse_kinematics_top #(
   parameter int ANGLE_FRAC_BITS = ptik_pkg::AFB_DEFAULT,
   parameter int CORDIC_STEPS    = ptik_pkg::STEPS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [ptik_pkg::TILT_W-1:0]       req_tilt_x,
   input  logic signed [ptik_pkg::TILT_W-1:0]       req_tilt_y,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [ptik_pkg::ANG_W-1:0]        rsp_joint_angle_one,
   output logic signed [ptik_pkg::ANG_W-1:0]        rsp_joint_angle_two,
   output logic signed [ptik_pkg::ANG_W-1:0]        rsp_joint_angle_three,
   output logic                                     rsp_pose_invalid
);

   localparam int LAT_SC    = CORDIC_STEPS + 2;
   localparam int LAT_MID   = 7;
   localparam int LAT_ROOT  = ptik_pkg::ROOT_W;
   localparam int LAT_ATAN  = CORDIC_STEPS + 4;
   localparam int TOTAL     = LAT_SC + LAT_MID + LAT_ROOT + 1 + LAT_ATAN + 1;
   localparam int MW        = ptik_pkg::MUL_W;

   // leg kind: legs one and three share link constants, leg two differs
   localparam int KA = 0;
   localparam int KB = 1;

   logic en;
   logic [TOTAL-1:0] vld_ff, vld_in;

   // whole pipe moves unless a finished response is held
   assign en        = !vld_ff[TOTAL-1] || !rsp_stall;
   assign req_stall = !en;
   assign rsp_valid = vld_ff[TOTAL-1];

   assign vld_in = {vld_ff[TOTAL-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // sin/cos of both tilts
   ptik_pkg::mval_type sx, cx, sy, cy;

   ptik_sincos #(.AFB(ANGLE_FRAC_BITS), .STEPS(CORDIC_STEPS)) u_sc_x (
      .clock (clock), .en (en), .tilt (req_tilt_x), .sin_q (sx), .cos_q (cx)
   );

   ptik_sincos #(.AFB(ANGLE_FRAC_BITS), .STEPS(CORDIC_STEPS)) u_sc_y (
      .clock (clock), .en (en), .tilt (req_tilt_y), .sin_q (sy), .cos_q (cy)
   );

   // stage m1: basic products
   ptik_pkg::mval_type cy2_ff, u_ff, v_ff;
   ptik_pkg::mval_type kcy_ff [2];
   // stage m2: sums and scaled cos^2
   ptik_pkg::mval_type g_ff [2];
   ptik_pkg::mval_type kc2_ff [2];
   ptik_pkg::mval_type kcy2_ff [2];
   ptik_pkg::mval_type ua_ff, uw_ff;
   // stage m3: per-leg a, w and link terms
   ptik_pkg::mval_type a3_ff [3];
   ptik_pkg::mval_type w3_ff [3];
   ptik_pkg::mval_type p3_ff [2];
   ptik_pkg::mval_type rb3_ff [2];
   ptik_pkg::mval_type db3_ff [2];
   // stage m4: offset terms h
   ptik_pkg::mval_type h4_ff [3];
   ptik_pkg::mval_type a4_ff [3];
   ptik_pkg::mval_type p4_ff [2];
   ptik_pkg::mval_type rb4_ff [2];
   ptik_pkg::mval_type db4_ff [2];
   // stage m5: r and denominator
   ptik_pkg::mval_type r5_ff [3];
   ptik_pkg::mval_type d5_ff [3];
   ptik_pkg::mval_type a5_ff [3];
   ptik_pkg::mval_type p5_ff [2];
   // stage m6: exact squares
   ptik_pkg::wide_type pp6_ff [2];
   ptik_pkg::wide_type aa6_ff [3];
   ptik_pkg::wide_type rr6_ff [3];
   ptik_pkg::mval_type d6_ff [3];
   ptik_pkg::mval_type a6_ff [3];
   // stage m7: root argument and validity
   logic [ptik_pkg::WIDE_W-1:0] b7_ff [3];
   ptik_pkg::mval_type a7_ff [3];
   ptik_pkg::mval_type d7_ff [3];
   logic bad7_ff;

   ptik_pkg::wide_type b_in [3];
   logic               bad_in;

   always_comb begin
      bad_in = 1'b0;
      for (int l = 0; l < 3; l++) begin
         b_in[l] = pp6_ff[(l == 1) ? KB : KA] + aa6_ff[l] - rr6_ff[l];
         if (b_in[l] < 0 || d6_ff[l] == 0) begin
            bad_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // m1
         cy2_ff     <= ptik_pkg::qmul(cy, cy);
         u_ff       <= ptik_pkg::qmul(cx, sy);
         v_ff       <= ptik_pkg::qmul(sx, ptik_pkg::Q_SQRT3);
         kcy_ff[KA] <= ptik_pkg::qmul(ptik_pkg::K_0025, cy);
         kcy_ff[KB] <= ptik_pkg::qmul(ptik_pkg::K_001, cy);
         // m2
         g_ff[0]     <= u_ff - v_ff;
         g_ff[1]     <= u_ff + v_ff;
         kc2_ff[KA]  <= ptik_pkg::qmul(ptik_pkg::K_0025, cy2_ff);
         kc2_ff[KB]  <= ptik_pkg::qmul(ptik_pkg::K_001, cy2_ff);
         kcy2_ff[KA] <= kcy_ff[KA];
         kcy2_ff[KB] <= kcy_ff[KB];
         ua_ff       <= ptik_pkg::qmul(ptik_pkg::K_001, u_ff);
         uw_ff       <= ptik_pkg::qmul(ptik_pkg::K_01, u_ff);
         // m3
         a3_ff[0] <= ptik_pkg::qmul(ptik_pkg::K_00125, g_ff[0]) - ptik_pkg::K_00325;
         w3_ff[0] <= ptik_pkg::K_013 - ptik_pkg::qmul(ptik_pkg::K_005, g_ff[0]);
         a3_ff[2] <= ptik_pkg::qmul(ptik_pkg::K_00125, g_ff[1]) - ptik_pkg::K_00325;
         w3_ff[2] <= ptik_pkg::K_013 - ptik_pkg::qmul(ptik_pkg::K_005, g_ff[1]);
         a3_ff[1] <= -ua_ff - ptik_pkg::K_0013;
         w3_ff[1] <= uw_ff + ptik_pkg::K_013;
         p3_ff[KA]  <= (ptik_pkg::K_0025 >>> 1) - kcy2_ff[KA];
         p3_ff[KB]  <= (ptik_pkg::K_001 >>> 1) - kcy2_ff[KB];
         rb3_ff[KA] <= kc2_ff[KA] - kcy2_ff[KA] - ptik_pkg::K_002975;
         rb3_ff[KB] <= kc2_ff[KB] - kcy2_ff[KB] - ptik_pkg::K_0119;
         db3_ff[KA] <= kc2_ff[KA] - ptik_pkg::K_004225;
         db3_ff[KB] <= kc2_ff[KB] - ptik_pkg::K_0169;
         // m4
         h4_ff[0] <= ptik_pkg::qmul(w3_ff[0], w3_ff[0]) >>> 2;
         h4_ff[1] <= ptik_pkg::qmul(w3_ff[1], w3_ff[1]);
         h4_ff[2] <= ptik_pkg::qmul(w3_ff[2], w3_ff[2]) >>> 2;
         for (int l = 0; l < 3; l++) begin
            a4_ff[l] <= a3_ff[l];
         end
         for (int k = 0; k < 2; k++) begin
            p4_ff[k]  <= p3_ff[k];
            rb4_ff[k] <= rb3_ff[k];
            db4_ff[k] <= db3_ff[k];
         end
         // m5
         for (int l = 0; l < 3; l++) begin
            r5_ff[l] <= rb4_ff[(l == 1) ? KB : KA] + h4_ff[l];
            d5_ff[l] <= db4_ff[(l == 1) ? KB : KA] + h4_ff[l];
            a5_ff[l] <= a4_ff[l];
         end
         p5_ff[KA] <= p4_ff[KA];
         p5_ff[KB] <= p4_ff[KB];
         // m6
         pp6_ff[KA] <= ptik_pkg::sqr(p5_ff[KA]);
         pp6_ff[KB] <= ptik_pkg::sqr(p5_ff[KB]);
         for (int l = 0; l < 3; l++) begin
            aa6_ff[l] <= ptik_pkg::sqr(a5_ff[l]);
            rr6_ff[l] <= ptik_pkg::sqr(r5_ff[l]);
            d6_ff[l]  <= d5_ff[l];
            a6_ff[l]  <= a5_ff[l];
         end
         // m7: a leg with a bad argument roots zero
         for (int l = 0; l < 3; l++) begin
            b7_ff[l] <= (b_in[l] < 0) ? '0 : ptik_pkg::WIDE_W'(b_in[l]);
            a7_ff[l] <= a6_ff[l];
            d7_ff[l] <= d6_ff[l];
         end
         bad7_ff <= bad_in;
      end
   end

   // per-leg root, numerator and atan
   logic [ptik_pkg::ANG_W-1:0] ang [3];
   ptik_pkg::ain_type          num_ff [3];

   for (genvar l = 0; l < 3; l++) begin : g_leg
      logic [ptik_pkg::ROOT_W-1:0] root;
      ptik_pkg::mval_type          a_dly;
      ptik_pkg::mval_type          d_dly;

      ptik_isqrt u_isqrt (
         .clock (clock), .en (en), .arg (b7_ff[l]), .root (root)
      );

      ptik_delay #(.W(MW), .DEPTH(LAT_ROOT)) u_a_dly (
         .clock (clock), .en (en), .d (a7_ff[l]), .q (a_dly)
      );

      ptik_delay #(.W(MW), .DEPTH(LAT_ROOT + 1)) u_d_dly (
         .clock (clock), .en (en), .d (d7_ff[l]), .q (d_dly)
      );

      // numerator 2*(a + sqrt(b))
      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[l] <= (ptik_pkg::ain_type'(a_dly) + ptik_pkg::ain_type'(root)) <<< 1;
         end
      end

      ptik_atan #(.AFB(ANGLE_FRAC_BITS), .STEPS(CORDIC_STEPS)) u_atan (
         .clock (clock), .en (en), .num (num_ff[l]), .den (d_dly), .ang (ang[l])
      );
   end

   logic bad_dly;

   ptik_delay #(.W(1), .DEPTH(LAT_ROOT + 1 + LAT_ATAN)) u_bad_dly (
      .clock (clock), .en (en), .d (bad7_ff), .q (bad_dly)
   );

   // output register
   logic [ptik_pkg::ANG_W-1:0] ang1_ff, ang2_ff, ang3_ff;
   logic                       inv_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ang1_ff <= bad_dly ? '0 : ang[0];
         ang2_ff <= bad_dly ? '0 : ang[1];
         ang3_ff <= bad_dly ? '0 : ang[2];
         inv_ff  <= bad_dly;
      end
   end

   assign rsp_joint_angle_one   = ang1_ff;
   assign rsp_joint_angle_two   = ang2_ff;
   assign rsp_joint_angle_three = ang3_ff;
   assign rsp_pose_invalid      = inv_ff;

   // an invalid pose never shows nonzero angles
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pose_invalid |->
         (rsp_joint_angle_one == '0 && rsp_joint_angle_two == '0 &&
          rsp_joint_angle_three == '0))
      else $error("invalid pose with nonzero angle");

   // a held response freezes the valid bit of every stage
   a_hold_pipe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(vld_ff))
      else $error("pipeline moved under stall");

   // an accepted request occupies the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> vld_ff[0])
      else $error("accepted request lost");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tilt platform joint angle pipeline. A
// bit-exact fixed-point predictor computes the three joint angles and the
// invalid flag for every accepted request. A scoreboard compares each
// accepted response in order. Directed corner poses come first, then random
// tilts with random idling and back-pressure on both channels.
// ----------------------------------------------------------------------------
import ptik_pkg::*;

typedef struct packed {
   logic [ANG_W-1:0] angle_one;
   logic [ANG_W-1:0] angle_two;
   logic [ANG_W-1:0] angle_three;
   logic             invalid;
} joint_pose_t;

class joint_pose_scoreboard;
   joint_pose_t pending_poses[$];
   int          error_count = 0;

   localparam int AFB   = AFB_DEFAULT;
   localparam int STEPS = STEPS_DEFAULT;

   function longint qm(longint a, longint b);
      return (a * b + (longint'(1) <<< (QF - 1))) >>> QF;
   endfunction

   function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bit_val;
      res = 0;
      bit_val = longint'(1) << 62;
      while (bit_val > v) bit_val = bit_val >> 2;
      while (bit_val != 0) begin
         if (v >= res + bit_val) begin
            v = v - (res + bit_val);
            res = (res >> 1) + bit_val;
         end else begin
            res = res >> 1;
         end
         bit_val = bit_val >> 2;
      end
      return res;
   endfunction

   function void sin_cos(logic signed [TILT_W-1:0] raw, output longint s, output longint c);
      longint z, x, y, dx, dy;
      bit     flip;
      z = longint'(raw) * (longint'(1) <<< (QF - AFB));
      x = Q_GAIN;
      y = 0;
      flip = 0;
      while (z > Q_PI) z = z - Q_TWO_PI;
      while (z < -longint'(Q_PI)) z = z + Q_TWO_PI;
      if (z > Q_HALF_PI) begin
         z = z - Q_PI;
         flip = 1;
      end else if (z < -longint'(Q_HALF_PI)) begin
         z = z + Q_PI;
         flip = 1;
      end
      for (int i = 0; i < STEPS && i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - ARC_TAB[i];
         end else begin
            x = x + dx; y = y - dy; z = z + ARC_TAB[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function longint atan_of(longint num, longint den);
      longint x, y, z, dx, dy;
      x = den; y = num; z = 0;
      if (x < 0) begin
         x = -x; y = -y;
      end
      while (x < (longint'(1) <<< 50) && y < (longint'(1) <<< 50)
             && y > -(longint'(1) <<< 50)) begin
         x = x * 2; y = y * 2;
      end
      for (int i = 0; i < STEPS && i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y < 0) begin
            x = x - dx; y = y + dy; z = z - ARC_TAB[i];
         end else begin
            x = x + dx; y = y - dy; z = z + ARC_TAB[i];
         end
      end
      if (z > Q_HALF_PI) z = Q_HALF_PI;
      if (z < -longint'(Q_HALF_PI)) z = -longint'(Q_HALF_PI);
      return z;
   endfunction

   function longint leg_angle(longint a, longint k, longint h, longint rc, longint dc,
                              longint cy, longint cy2, inout bit bad);
      longint p, kc2, r, d, b, z;
      p = (k >>> 1) - qm(k, cy);
      kc2 = qm(k, cy2);
      r = kc2 - qm(k, cy) - rc + h;
      d = kc2 - dc + h;
      b = p * p + a * a - r * r;
      if (b < 0 || d == 0) begin
         bad = 1;
         return 0;
      end
      z = atan_of(2 * (a + longint'(int_sqrt(b))), d);
      return (z + (longint'(1) <<< (QF - AFB - 1))) >>> (QF - AFB);
   endfunction

   function joint_pose_t predict_pose(logic signed [TILT_W-1:0] tx,
                                      logic signed [TILT_W-1:0] ty);
      longint sx, cx, sy, cy, cy2, u, v, g, w, a, h, a1, a2, a3;
      bit bad;
      joint_pose_t res;
      bad = 0;
      sin_cos(tx, sx, cx);
      sin_cos(ty, sy, cy);
      cy2 = qm(cy, cy);
      u = qm(cx, sy);
      v = qm(sx, Q_SQRT3);
      g = u - v;
      a = qm(K_00125, g) - K_00325;
      w = K_013 - qm(K_005, g);
      h = qm(w, w) >>> 2;
      a1 = leg_angle(a, K_0025, h, K_002975, K_004225, cy, cy2, bad);
      a = -qm(K_001, u) - K_0013;
      w = qm(K_01, u) + K_013;
      h = qm(w, w);
      a2 = leg_angle(a, K_001, h, K_0119, K_0169, cy, cy2, bad);
      g = u + v;
      a = qm(K_00125, g) - K_00325;
      w = K_013 - qm(K_005, g);
      h = qm(w, w) >>> 2;
      a3 = leg_angle(a, K_0025, h, K_002975, K_004225, cy, cy2, bad);
      if (bad) begin
         a1 = 0; a2 = 0; a3 = 0;
      end
      res.angle_one   = a1[ANG_W-1:0];
      res.angle_two   = a2[ANG_W-1:0];
      res.angle_three = a3[ANG_W-1:0];
      res.invalid     = bad;
      return res;
   endfunction

   function void note_request(logic signed [TILT_W-1:0] tx, logic signed [TILT_W-1:0] ty);
      pending_poses.push_back(predict_pose(tx, ty));
   endfunction

   function void check_response(joint_pose_t got);
      joint_pose_t want;
      if (pending_poses.size() == 0) begin
         $error("response with no request pending");
         error_count++;
         return;
      end
      want = pending_poses.pop_front();
      if (got.angle_one !== want.angle_one) begin
         $error("joint_angle_one expected %h actual %h", want.angle_one, got.angle_one);
         error_count++;
      end
      if (got.angle_two !== want.angle_two) begin
         $error("joint_angle_two expected %h actual %h", want.angle_two, got.angle_two);
         error_count++;
      end
      if (got.angle_three !== want.angle_three) begin
         $error("joint_angle_three expected %h actual %h", want.angle_three,
                got.angle_three);
         error_count++;
      end
      if (got.invalid !== want.invalid) begin
         $error("pose_invalid expected %b actual %b", want.invalid, got.invalid);
         error_count++;
      end
   endfunction
endclass

module tb;
   // pipeline depth for the default configuration
   localparam int PIPE_LATENCY = 2 * STEPS_DEFAULT + 47;
   localparam int RANDOM_ITEMS = 830;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [TILT_W-1:0] req_tilt_x = 0;
   logic signed [TILT_W-1:0] req_tilt_y = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [ANG_W-1:0] rsp_joint_angle_one;
   logic signed [ANG_W-1:0] rsp_joint_angle_two;
   logic signed [ANG_W-1:0] rsp_joint_angle_three;
   logic rsp_pose_invalid;

   joint_pose_scoreboard pose_board = new();

   // quiet turns off random idling on both sides; hold_cycles forces a long
   // receiver hold-off counted down in the receiver process
   bit quiet = 0;
   int hold_cycles = 0;

   platform_tilt_inverse_kinematics_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_tilt_x(req_tilt_x), .req_tilt_y(req_tilt_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_joint_angle_one(rsp_joint_angle_one),
      .rsp_joint_angle_two(rsp_joint_angle_two),
      .rsp_joint_angle_three(rsp_joint_angle_three),
      .rsp_pose_invalid(rsp_pose_invalid)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // receiver: random stall plus forced hold-off, and response checking on
   // the values seen just before the edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         pose_board.check_response({rsp_joint_angle_one, rsp_joint_angle_two,
                                    rsp_joint_angle_three, rsp_pose_invalid});
      end
      if (reset) begin
         rsp_stall <= 0;
      end else if (hold_cycles > 0) begin
         rsp_stall <= 1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 9);
      end
   end

   // one request: optional idle gap, then offer until accepted
   task automatic send_tilt(input logic signed [TILT_W-1:0] tx,
                            input logic signed [TILT_W-1:0] ty);
      while (!quiet && $urandom_range(99) < 9) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid  <= 1;
      req_tilt_x <= tx;
      req_tilt_y <= ty;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pose_board.note_request(tx, ty);
   endtask

   // mostly in-range tilts, some raw 16-bit patterns to exercise reduction
   function automatic logic signed [TILT_W-1:0] random_tilt();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) return TILT_W'($urandom_range(2 * 3000) - 3000);
      if (pick < 85) return TILT_W'($urandom_range(51471) - 25736);
      return TILT_W'($urandom);
   endfunction

   task automatic wait_drained();
      req_valid <= 0;
      @(posedge clock);
      while (pose_board.pending_poses.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: zero pose, field extremes, half pi, full 16-bit corners
      send_tilt(0, 0);
      send_tilt(25735, 25735);
      send_tilt(-25736, -25736);
      send_tilt(25735, -25736);
      send_tilt(-25736, 25735);
      send_tilt(32767, -32768);
      send_tilt(-32768, 32767);
      send_tilt(-1, -1);
      send_tilt(1, 1);
      send_tilt(12868, 0);
      send_tilt(0, 12868);
      send_tilt(-12868, 0);
      send_tilt(0, -12868);
      send_tilt(12868, 12868);
      send_tilt(25736 / 2 + 1, -12869);
      send_tilt(16'sh5555, 16'shAAAA);
      send_tilt(16'shAAAA, 16'sh5555);
      send_tilt(800, -800);
      send_tilt(-4000, 4000);
      send_tilt(2000, 2000);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // stretch with no idling on either side
         if (n == 250) quiet = 1;
         if (n == 400) quiet = 0;
         // long hold-off while requests keep coming, so the pipe backs up
         if (n == 500) hold_cycles = 3 * PIPE_LATENCY;
         // sender pause until everything is back
         if (n == 650) wait_drained();
         send_tilt(random_tilt(), random_tilt());
      end
      req_valid <= 0;

      while (pose_board.pending_poses.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 20) @(posedge clock);
      if (pose_board.error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #20000000;
      $display("simulation failed");
      $finish;
   end
endmodule
